// ===== src/sedsp_pkg.sv =====
// Shared types, constants and number-format helpers for the sound effect DSP sequencer.
// Used by sedsp_ctrl, sedsp_datapath and sound_effect_dsp_sequencer; depends on nothing.
package sedsp_pkg;

    // Storage sizes.
    localparam int PROGRAM_STEPS  = 128;
    localparam int WORK_MEM_WORDS = 65536;
    localparam int PS_AW          = $clog2(PROGRAM_STEPS);
    localparam int WM_AW          = $clog2(WORK_MEM_WORDS);
    localparam int COEF_WORDS     = 64;
    localparam int COEF_AW        = 6;
    localparam int TEMP_WORDS     = 128;
    localparam int TEMP_AW        = 7;
    localparam int RING_MIN_WORDS = 8 * 1024;

    // Configuration register indexes (bit 2 of the byte address).
    localparam logic REG_RING_SIZE = 1'b0;
    localparam logic REG_RING_BASE = 1'b1;

    typedef enum logic [3:0] {
        OP_PROG   = 4'd0,
        OP_COEF   = 4'd1,
        OP_ADDR   = 4'd2,
        OP_EXTIN  = 4'd3,
        OP_MEMWR  = 4'd4,
        OP_MIXADD = 4'd5,
        OP_START  = 4'd6,
        OP_RUN    = 4'd7,
        OP_RDEFF  = 4'd8,
        OP_RDMEM  = 4'd9
    } t_opcode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OP,
        ST_RDOUT,
        ST_SCAN,
        ST_SCAN_END,
        ST_FETCH,
        ST_DECODE,
        ST_EXEC,
        ST_ACC,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             clr_en;
        logic [WM_AW-1:0] clr_addr;
        logic             latch;
        logic             op_exec;
        logic             start_init;
        logic             rd_issue;
        logic             out_load;
        logic [PS_AW-1:0] prog_addr;
        logic             scan_rd;
        logic             dec;
        logic             exe;
        logic             acc;
        logic             fin;
        logic             mixclr;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_opcode        op;
        logic           halted;
        logic [PS_AW:0] last_step;
    } t_stat;

    typedef struct packed {
        logic [1:0] ring_size_code;
        logic [3:0] ring_base;
    } t_cfg;

    // Saturate a 27-bit signed value to 24 bits.
    function automatic logic [23:0] clamp24(input logic signed [26:0] v);
        if (v < -27'sd8388608) begin
            return 24'h800000;
        end else if (v > 27'sd8388607) begin
            return 24'h7fffff;
        end
        return v[23:0];
    endfunction

    // Pack a 24-bit sample into sign, 4-bit exponent and 11-bit mantissa.
    function automatic logic [15:0] pack_float(input logic [23:0] v);
        logic        sign;
        logic [23:0] t;
        logic [3:0]  e;
        logic        found;
        logic [23:0] vs;
        logic [10:0] mant;
        sign  = v[23];
        t     = v ^ {v[22:0], 1'b0};
        e     = 4'd12;
        found = 1'b0;
        for (int i = 0; i < 12; i++) begin
            if (!found && t[23-i]) begin
                e     = 4'(i);
                found = 1'b1;
            end
        end
        vs   = v << e;
        mant = (e == 4'd12) ? v[10:0] : vs[21:11];
        return {sign, e, mant};
    endfunction

    // Expand a packed word back to a 24-bit signed sample.
    function automatic logic [23:0] unpack_float(input logic [15:0] w);
        logic        sign;
        logic [3:0]  e;
        logic [23:0] u;
        sign = w[15];
        e    = w[14:11];
        u    = {2'b00, w[10:0], 11'd0};
        if (e > 4'd11) begin
            e     = 4'd11;
            u[22] = sign;
        end else begin
            u[22] = ~sign;
        end
        u[23] = sign;
        return 24'($signed(u) >>> e);
    endfunction

endpackage

// ===== src/sedsp_ctrl.sv =====
// Controller state machine: clearing pass, transaction dispatch, program scan and step phases.
// Depends on sedsp_pkg; drives sedsp_datapath through a command struct.
module sedsp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  sedsp_pkg::t_stat i_stat,
    output sedsp_pkg::t_cmd  o_cmd
);

    sedsp_pkg::t_state r_state, n_state;
    logic [sedsp_pkg::WM_AW-1:0] r_clr;
    logic [sedsp_pkg::PS_AW-1:0] r_step;
    logic [sedsp_pkg::PS_AW-1:0] r_scan;
    logic                        r_out_valid;
    logic                        w_out_free;
    logic                        w_last_step;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_last_step = ({1'b0, r_step} + 1'b1) == i_stat.last_step;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sedsp_pkg::ST_CLEAR: begin
                if (r_clr == '1) n_state = sedsp_pkg::ST_IDLE;
            end
            sedsp_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sedsp_pkg::ST_OP;
            end
            sedsp_pkg::ST_OP: begin
                unique case (i_stat.op) inside
                    sedsp_pkg::OP_START: n_state = sedsp_pkg::ST_SCAN;
                    sedsp_pkg::OP_RUN: begin
                        if (i_stat.halted) n_state = sedsp_pkg::ST_IDLE;
                        else if (i_stat.last_step == '0) n_state = sedsp_pkg::ST_FINISH;
                        else n_state = sedsp_pkg::ST_FETCH;
                    end
                    sedsp_pkg::OP_RDEFF, sedsp_pkg::OP_RDMEM: n_state = sedsp_pkg::ST_RDOUT;
                    default: n_state = sedsp_pkg::ST_IDLE;
                endcase
            end
            sedsp_pkg::ST_RDOUT: begin
                if (w_out_free) n_state = sedsp_pkg::ST_IDLE;
            end
            sedsp_pkg::ST_SCAN: begin
                if (r_scan == sedsp_pkg::PS_AW'(sedsp_pkg::PROGRAM_STEPS - 1)) begin
                    n_state = sedsp_pkg::ST_SCAN_END;
                end
            end
            sedsp_pkg::ST_SCAN_END: n_state = sedsp_pkg::ST_IDLE;
            sedsp_pkg::ST_FETCH:    n_state = sedsp_pkg::ST_DECODE;
            sedsp_pkg::ST_DECODE:   n_state = sedsp_pkg::ST_EXEC;
            sedsp_pkg::ST_EXEC:     n_state = sedsp_pkg::ST_ACC;
            sedsp_pkg::ST_ACC: begin
                n_state = w_last_step ? sedsp_pkg::ST_FINISH : sedsp_pkg::ST_FETCH;
            end
            sedsp_pkg::ST_FINISH:   n_state = sedsp_pkg::ST_IDLE;
            default:                n_state = sedsp_pkg::ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd           = '0;
        o_cmd.clr_addr  = r_clr;
        o_cmd.prog_addr = (r_state == sedsp_pkg::ST_SCAN) ? r_scan : r_step;
        o_in_ready      = 1'b0;
        unique case (r_state)
            sedsp_pkg::ST_CLEAR: o_cmd.clr_en = 1'b1;
            sedsp_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            sedsp_pkg::ST_OP: begin
                o_cmd.op_exec    = 1'b1;
                o_cmd.start_init = (i_stat.op == sedsp_pkg::OP_START);
                o_cmd.rd_issue   = (i_stat.op == sedsp_pkg::OP_RDMEM);
                o_cmd.mixclr     = (i_stat.op == sedsp_pkg::OP_RUN) && i_stat.halted;
            end
            sedsp_pkg::ST_RDOUT:    o_cmd.out_load = w_out_free;
            sedsp_pkg::ST_SCAN:     o_cmd.scan_rd  = 1'b1;
            sedsp_pkg::ST_SCAN_END: o_cmd.scan_rd  = 1'b0;
            sedsp_pkg::ST_FETCH:    o_cmd.dec      = 1'b0;
            sedsp_pkg::ST_DECODE:   o_cmd.dec      = 1'b1;
            sedsp_pkg::ST_EXEC:     o_cmd.exe      = 1'b1;
            sedsp_pkg::ST_ACC:      o_cmd.acc      = 1'b1;
            sedsp_pkg::ST_FINISH:   o_cmd.fin      = 1'b1;
            default:                o_cmd.fin      = 1'b0;
        endcase
    end

    // State, counters and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sedsp_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_step      <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sedsp_pkg::ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == sedsp_pkg::ST_OP) begin
                r_step <= '0;
                r_scan <= '0;
            end
            if (r_state == sedsp_pkg::ST_SCAN) r_scan <= r_scan + 1'b1;
            if (r_state == sedsp_pkg::ST_ACC) r_step <= r_step + 1'b1;
            if (o_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    // A program step only executes while the program is started.
    a_exec_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exe |-> !i_stat.halted)
        else $error("step executed while halted");

    // The step being executed lies below the program end.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exe |-> ({1'b0, r_step} < i_stat.last_step))
        else $error("step index beyond program end");

    // A result only appears after a read transaction.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == sedsp_pkg::ST_RDOUT)
        else $error("result without read");

    // The end-of-program phase lasts a single cycle.
    a_finish_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sedsp_pkg::ST_FINISH |=> r_state == sedsp_pkg::ST_IDLE)
        else $error("finish phase did not return to idle");

endmodule

// ===== src/sedsp_datapath.sv =====
// Datapath: program, coefficient, temp and work memories, register files, MAC and shifter.
// Depends on sedsp_pkg; controlled by sedsp_ctrl through command and status structs.
module sedsp_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sedsp_pkg::t_cmd    i_cmd,
    output sedsp_pkg::t_stat   o_stat,
    input  sedsp_pkg::t_cfg    i_cfg,
    input  logic [3:0]         i_opcode,
    input  logic [15:0]        i_address,
    input  logic [15:0]        i_data,
    input  logic signed [19:0] i_mix_sample,
    output logic [15:0]        o_read_data
);

    localparam int PS = sedsp_pkg::PROGRAM_STEPS;
    localparam int WA = sedsp_pkg::WM_AW;
    localparam int PA = sedsp_pkg::PS_AW;

    // Latched transaction.
    logic [3:0]  r_op;
    logic [15:0] r_addr;
    logic [15:0] r_data;
    logic [19:0] r_ms;

    // Memories and their read registers.
    logic [15:0] m_prog [4][PS];
    logic [15:0] m_coef [sedsp_pkg::COEF_WORDS];
    logic [23:0] m_temp [sedsp_pkg::TEMP_WORDS];
    logic [15:0] m_work [sedsp_pkg::WORK_MEM_WORDS];
    logic [63:0] r_ins;
    logic [PA-1:0] r_prog_idx;
    logic        r_scan_v;
    logic [15:0] r_coef_q;
    logic [23:0] r_temp_q;
    logic [15:0] r_work_q;
    logic [15:0] r_rdata;

    // Register files and machine state.
    logic [19:0] r_mix [16];
    logic [15:0] r_ext [2];
    logic [23:0] r_mregs [32];
    logic [15:0] r_addrtab [32];
    logic [15:0] r_eff [16];
    logic signed [25:0] r_acc;
    logic [12:0] r_frac;
    logic [23:0] r_ylatch;
    logic [11:0] r_aoff;
    logic [23:0] r_ilatch;
    logic [23:0] r_rlatch;
    logic [1:0]  r_rpend;
    logic        r_wpend;
    logic [WA-1:0] r_aaddr;
    logic [15:0] r_wword;
    logic [15:0] r_dc;
    logic [PA:0] r_last;
    logic        r_halted;
    logic signed [36:0] r_prod;
    logic signed [25:0] r_b;

    // Instruction fields.
    logic [6:0] f_tra, f_twa;
    logic       f_twt, f_xsel, f_iwt, f_table, f_mwt, f_mrd, f_ewt, f_adrl, f_frcl;
    logic [1:0] f_ysel, f_shift;
    logic [5:0] f_ira, f_coef;
    logic [4:0] f_iwa, f_masa;
    logic [3:0] f_ewa;
    logic       f_yrl, f_negb, f_zero, f_bsel, f_nofl, f_adreb, f_nxadr;

    assign f_tra   = r_ins[14:8];
    assign f_twt   = r_ins[7];
    assign f_twa   = r_ins[6:0];
    assign f_xsel  = r_ins[31];
    assign f_ysel  = r_ins[30:29];
    assign f_ira   = r_ins[27:22];
    assign f_iwt   = r_ins[21];
    assign f_iwa   = r_ins[20:16];
    assign f_table = r_ins[47];
    assign f_mwt   = r_ins[46];
    assign f_mrd   = r_ins[45];
    assign f_ewt   = r_ins[44];
    assign f_ewa   = r_ins[43:40];
    assign f_adrl  = r_ins[39];
    assign f_frcl  = r_ins[38];
    assign f_shift = r_ins[37:36];
    assign f_yrl   = r_ins[35];
    assign f_negb  = r_ins[34];
    assign f_zero  = r_ins[33];
    assign f_bsel  = r_ins[32];
    assign f_nofl  = r_ins[56];
    assign f_coef  = r_ins[62:57];
    assign f_masa  = r_ins[54:50];
    assign f_adreb = r_ins[49];
    assign f_nxadr = r_ins[48];

    // Indexes derived from the latched transaction.
    logic [17:0]   w_addr_ext;
    logic [WA-1:0] w_item_idx;
    logic [6:0]    w_prog_step;
    logic [6:0]    w_tidx, w_twidx;

    assign w_addr_ext  = {2'b00, r_addr};
    assign w_item_idx  = w_addr_ext[WA-1:0];
    assign w_prog_step = r_addr[8:2];
    assign w_tidx      = f_tra + r_dc[6:0];
    assign w_twidx     = f_twa + r_dc[6:0];

    // Step arithmetic: input latch, operands, shifter and ring address.
    logic [23:0]        n_il;
    logic signed [25:0] w_bsrc, w_b;
    logic signed [23:0] w_x;
    logic [12:0]        w_ymask;
    logic signed [12:0] w_y;
    logic [23:0]        w_sh;
    logic [17:0]        w_asum, w_afull;
    logic [15:0]        w_ring_mask, w_amask;
    logic [WA-1:0]      n_aaddr;
    logic signed [36:0] w_prod_sh;

    always_comb begin
        n_il = r_ilatch;
        if (f_ira <= 6'h1f) n_il = r_mregs[f_ira[4:0]];
        else if (f_ira <= 6'h2f) n_il = {r_mix[f_ira[3:0]], 4'h0};
        else if (f_ira <= 6'h31) n_il = {r_ext[f_ira[0]], 8'h00};
        if (f_iwt && (f_ira == {1'b0, f_iwa})) n_il = r_rlatch;
    end

    always_comb begin
        w_bsrc = f_bsel ? r_acc : 26'(signed'(r_temp_q));
        w_b    = f_zero ? 26'sd0 : (f_negb ? -w_bsrc : w_bsrc);
        w_x    = f_xsel ? signed'(n_il) : signed'(r_temp_q);
        case (f_ysel)
            2'd0:    w_ymask = r_frac;
            2'd1:    w_ymask = r_coef_q[15:3];
            2'd2:    w_ymask = r_ylatch[23:11];
            default: w_ymask = {1'b0, r_ylatch[15:4]};
        endcase
        w_y = signed'(w_ymask);
        case (f_shift)
            2'd0:    w_sh = sedsp_pkg::clamp24({r_acc[25], r_acc});
            2'd1:    w_sh = sedsp_pkg::clamp24({r_acc, 1'b0});
            2'd2:    w_sh = {r_acc[22:0], 1'b0};
            default: w_sh = r_acc[23:0];
        endcase
    end

    always_comb begin
        w_asum = {2'b00, r_addrtab[f_masa]}
               + (f_table ? 18'd0 : {2'b00, r_dc})
               + (f_adreb ? {6'd0, r_aoff} : 18'd0)
               + {17'd0, f_nxadr};
        w_ring_mask = 16'((32'(sedsp_pkg::RING_MIN_WORDS) << i_cfg.ring_size_code) - 1);
        w_amask     = f_table ? w_asum[15:0] : (w_asum[15:0] & w_ring_mask);
        w_afull     = {2'b00, w_amask} + {2'b00, i_cfg.ring_base, 12'd0};
        n_aaddr     = w_afull[WA-1:0];
    end

    assign w_prod_sh = r_prod >>> 12;

    // Work memory port selection.
    logic          w_wm_we;
    logic [WA-1:0] w_wm_waddr;
    logic [15:0]   w_wm_wdata;
    logic          w_wm_re;
    logic [WA-1:0] w_wm_raddr;

    always_comb begin
        w_wm_we    = i_cmd.clr_en
                   | (i_cmd.op_exec && (r_op == sedsp_pkg::OP_MEMWR))
                   | (i_cmd.exe && (r_rpend == 2'd0) && r_wpend)
                   | (i_cmd.fin && r_wpend);
        w_wm_waddr = i_cmd.clr_en ? i_cmd.clr_addr : (i_cmd.op_exec ? w_item_idx : r_aaddr);
        w_wm_wdata = i_cmd.clr_en ? 16'd0 : (i_cmd.op_exec ? r_data : r_wword);
        w_wm_re    = i_cmd.rd_issue || (i_cmd.dec && (r_rpend != 2'd0));
        w_wm_raddr = i_cmd.rd_issue ? w_item_idx : r_aaddr;
    end

    always_ff @(posedge i_clk) begin
        if (w_wm_we) m_work[w_wm_waddr] <= w_wm_wdata;
        if (w_wm_re) r_work_q <= m_work[w_wm_raddr];
    end

    // Program memory, four 16-bit lanes, read every cycle.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (i_cmd.clr_en && (i_cmd.clr_addr < WA'(PS))) begin
                m_prog[k][i_cmd.clr_addr[PA-1:0]] <= 16'd0;
            end else if (i_cmd.op_exec && (r_op == sedsp_pkg::OP_PROG)
                         && ({1'b0, w_prog_step} < 8'(PS)) && (r_addr[1:0] == 2'(k))) begin
                m_prog[k][w_prog_step[PA-1:0]] <= r_data;
            end
        end
        r_ins      <= {m_prog[3][i_cmd.prog_addr], m_prog[2][i_cmd.prog_addr],
                       m_prog[1][i_cmd.prog_addr], m_prog[0][i_cmd.prog_addr]};
        r_prog_idx <= i_cmd.prog_addr;
    end

    // Coefficient and temp memories.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            m_coef[i_cmd.clr_addr[sedsp_pkg::COEF_AW-1:0]] <= 16'd0;
            m_temp[i_cmd.clr_addr[sedsp_pkg::TEMP_AW-1:0]] <= 24'd0;
        end else begin
            if (i_cmd.op_exec && (r_op == sedsp_pkg::OP_COEF)) m_coef[r_addr[5:0]] <= r_data;
            if (i_cmd.exe && f_twt) m_temp[w_twidx] <= w_sh;
        end
        if (i_cmd.dec) begin
            r_coef_q <= m_coef[f_coef];
            r_temp_q <= m_temp[w_tidx];
        end
    end

    // Transaction latch, product pipeline and read result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_opcode;
            r_addr <= i_address;
            r_data <= i_data;
            r_ms   <= i_mix_sample;
        end
        if (i_cmd.exe) begin
            r_prod <= w_x * w_y;
            r_b    <= w_b;
        end
        if (i_cmd.out_load) begin
            r_rdata <= (r_op == sedsp_pkg::OP_RDEFF) ? r_eff[r_addr[3:0]] : r_work_q;
        end
    end

    // Machine state with reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mix[i] <= '0;
                r_eff[i] <= '0;
            end
            for (int i = 0; i < 32; i++) begin
                r_mregs[i]   <= '0;
                r_addrtab[i] <= '0;
            end
            r_ext[0] <= '0;
            r_ext[1] <= '0;
            r_acc    <= '0;
            r_frac   <= '0;
            r_ylatch <= '0;
            r_aoff   <= '0;
            r_ilatch <= '0;
            r_rlatch <= '0;
            r_rpend  <= '0;
            r_wpend  <= 1'b0;
            r_aaddr  <= '0;
            r_wword  <= '0;
            r_dc     <= '0;
            r_last   <= '0;
            r_halted <= 1'b1;
            r_scan_v <= 1'b0;
        end else begin
            r_scan_v <= i_cmd.scan_rd;
            // Table and mix loads.
            if (i_cmd.op_exec) begin
                case (r_op)
                    sedsp_pkg::OP_ADDR:   r_addrtab[r_addr[4:0]] <= r_data;
                    sedsp_pkg::OP_EXTIN:  r_ext[r_addr[0]] <= r_data;
                    sedsp_pkg::OP_MIXADD: r_mix[r_addr[3:0]] <= r_mix[r_addr[3:0]] + r_ms;
                    default: ;
                endcase
            end
            // Program start and end-of-program scan.
            if (i_cmd.start_init) begin
                r_halted <= 1'b0;
                r_last   <= '0;
            end
            if (r_scan_v && (r_ins != 64'd0)) r_last <= {1'b0, r_prog_idx} + 1'b1;
            // Step execution.
            if (i_cmd.exe) begin
                r_ilatch <= n_il;
                if (f_iwt) r_mregs[f_iwa] <= r_rlatch;
                if (f_yrl) r_ylatch <= n_il;
                if (f_frcl) r_frac <= (f_shift == 2'd3) ? {1'b0, w_sh[11:0]} : w_sh[23:11];
                if (r_rpend != 2'd0) begin
                    r_rlatch <= (r_rpend == 2'd2) ? {r_work_q, 8'h00}
                                                  : sedsp_pkg::unpack_float(r_work_q);
                end
                r_rpend <= f_mrd ? (f_nofl ? 2'd2 : 2'd1) : 2'd0;
                r_wpend <= f_mwt | (r_wpend & (r_rpend != 2'd0));
                if (f_mwt) r_wword <= f_nofl ? w_sh[23:8] : sedsp_pkg::pack_float(w_sh);
                r_aaddr <= n_aaddr;
                if (f_adrl) begin
                    r_aoff <= (f_shift == 2'd3) ? w_sh[23:12] : {{4{n_il[23]}}, n_il[23:16]};
                end
                if (f_ewt) r_eff[f_ewa] <= w_sh[23:8];
            end
            if (i_cmd.acc) r_acc <= w_prod_sh[25:0] + r_b;
            // End of program.
            if (i_cmd.fin) begin
                r_wpend <= 1'b0;
                r_dc    <= r_dc - 1'b1;
            end
            if (i_cmd.fin || i_cmd.mixclr) begin
                for (int i = 0; i < 16; i++) r_mix[i] <= '0;
            end
        end
    end

    assign o_stat.op        = sedsp_pkg::t_opcode'(r_op);
    assign o_stat.halted    = r_halted;
    assign o_stat.last_step = r_last;
    assign o_read_data      = r_rdata;

endmodule

// ===== src/sound_effect_dsp_sequencer.sv =====
// Top level of the sound effect DSP sequencer: APB configuration registers and the block.
// Depends on sedsp_pkg, sedsp_ctrl and sedsp_datapath.
//
//   Channel   Direction  Handshake           Payload
//   in        to block   i_valid / o_ready   i_opcode, i_address, i_data, i_mix_sample
//   out       from block o_valid / i_ready   o_read_data
//   config    APB        i_psel, i_penable   i_paddr, i_pwdata, o_prdata
//
// After reset a clearing pass zeroes the memories; no transaction is taken then,
// while configuration writes are. Loads pass through the operation state, reads also
// through a readout state that waits on the output register. Start scans the whole
// program. Run passes each program step through fetch, operand read, multiply and
// accumulate, all on the single shared MAC and memory ports.
module sound_effect_dsp_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_opcode,
    input  logic [15:0]        i_address,
    input  logic [15:0]        i_data,
    input  logic signed [19:0] i_mix_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_read_data,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output logic [31:0]        o_prdata,
    output logic               o_pready
);

    sedsp_pkg::t_cfg  r_cfg;
    sedsp_pkg::t_cmd  w_cmd;
    sedsp_pkg::t_stat w_stat;
    logic             w_cfg_wr;

    // Configuration register writes.
    assign w_cfg_wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_cfg_wr) begin
            if (i_paddr[2] == sedsp_pkg::REG_RING_SIZE) r_cfg.ring_size_code <= i_pwdata[1:0];
            else r_cfg.ring_base <= i_pwdata[3:0];
        end
    end

    // Register readback.
    assign o_prdata = (i_paddr[2] == sedsp_pkg::REG_RING_BASE) ? {28'd0, r_cfg.ring_base}
                                                               : {30'd0, r_cfg.ring_size_code};
    assign o_pready = 1'b1;

    sedsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    sedsp_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg        (r_cfg),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_data       (i_data),
        .i_mix_sample (i_mix_sample),
        .o_read_data  (o_read_data)
    );

endmodule
